[rtl/core/bra_pkg.sv]
// Shared widths and output limits for the bounded rational approximation block.
package bra_pkg;

    // Fixed field widths
    localparam int VALUE_W = 32;
    localparam int NUM_W   = 24;
    localparam int DEN_W   = 8;

    // Output saturation limits
    localparam logic [NUM_W-2:0] NUM_MAG_MAX = '1;
    localparam logic [DEN_W-1:0] DEN_MAX     = '1;

    // Divider job codes
    typedef logic [1:0] t_div_job;
    localparam t_div_job JOB_MOD = 2'd0;   // remainder of numerator by denominator
    localparam t_div_job JOB_NUM = 2'd1;   // numerator divided by gcd
    localparam t_div_job JOB_DEN = 2'd2;   // denominator divided by gcd

endpackage

[rtl/core/bounded_rational_approximation.sv]
// Top level: closest fraction with bounded denominator to a signed fixed-point value.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------------------
//  in      | request   | i_in_valid / o_in_ready    | i_value
//  out     | result    | o_out_valid / i_out_ready  | o_numerator, o_denominator,
//          |           |                            | o_decimal_fallback
//
// Search: per denominator, product e*best_d (S_MULA), product best_e*d (S_MULB), compare (S_CMP),
// for denominators up to DENOMINATOR_LIMIT, ending early at the first exact hit.
// Reduction: three restoring-divider passes (remainder, numerator, denominator) and a
// binary gcd of the best denominator and the remainder.
// A zero input skips the search. Reset is synchronous; no clearing pass.
// A stalled output holds the next result in the done state, and with it every later request.
module bounded_rational_approximation
    import bra_pkg::*;
#(
    parameter int DENOMINATOR_LIMIT = 128,
    parameter int FRACTION_BITS     = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic signed [VALUE_W-1:0] i_value,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [NUM_W-1:0]   o_numerator,
    output logic        [DEN_W-1:0]   o_denominator,
    output logic                      o_decimal_fallback
);

    // Derived widths
    localparam int DW  = $clog2(DENOMINATOR_LIMIT + 1);   // denominator
    localparam int MW  = VALUE_W + 1;                     // magnitude
    localparam int SW  = VALUE_W + DW;                    // magnitude * denominator
    localparam int NW  = SW - FRACTION_BITS + 1;          // candidate numerator
    localparam int EW  = FRACTION_BITS;                   // error, at most half
    localparam int PW  = EW + DW;                         // cross product
    localparam int CW  = $clog2(NW);                      // divider step count
    localparam int KW  = $clog2(DW + 1);                  // gcd common shift
    localparam int QW  = (NW > NUM_W) ? NW : NUM_W;
    localparam int DXW = (DW > DEN_W) ? DW : DEN_W;

    localparam logic [DW-1:0] D_LIMIT = DW'(DENOMINATOR_LIMIT);
    localparam logic [CW-1:0] CNT_END = CW'(NW - 1);

    // Sequencer codes
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MULA = 3'd1;
    localparam logic [2:0] S_MULB = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_GCD  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]       r_state;
    logic             r_out_valid;

    logic [MW-1:0]    r_mag;
    logic             r_neg;
    logic [SW-1:0]    r_scaled;
    logic [DW-1:0]    r_d;
    logic [NW-1:0]    r_n;
    logic [EW-1:0]    r_e;
    logic [PW-1:0]    r_p;
    logic [PW-1:0]    r_q;
    logic             r_found;
    logic [NW-1:0]    r_bn;
    logic [DW-1:0]    r_bd;
    logic [EW-1:0]    r_be;

    logic [NW-1:0]    r_dq;
    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_dvs;
    logic [CW-1:0]    r_cnt;
    t_div_job         r_job;

    logic [DW-1:0]    r_ga;
    logic [DW-1:0]    r_gb;
    logic [KW-1:0]    r_k;
    logic [DW-1:0]    r_g;
    logic [NW-1:0]    r_qn;
    logic [DW-1:0]    r_qd;

    logic signed [NUM_W-1:0] r_num;
    logic [DEN_W-1:0]        r_den;
    logic                    r_fb;

    // Magnitude of the incoming value; the most negative code maps to 2^31 exactly
    logic [MW-1:0] v_ext;
    logic [MW-1:0] mag_c;
    assign v_ext = {i_value[VALUE_W-1], i_value};
    assign mag_c = i_value[VALUE_W-1] ? (~v_ext + MW'(1)) : v_ext;

    // Round half up: numerator and error come straight from the scaled bits
    logic [FRACTION_BITS-1:0] low_c;
    logic                     rnd_c;
    logic [NW-1:0]            n_c;
    logic [EW-1:0]            e_c;
    assign low_c = r_scaled[FRACTION_BITS-1:0];
    assign rnd_c = low_c[FRACTION_BITS-1];
    assign n_c   = {1'b0, r_scaled[SW-1:FRACTION_BITS]} + NW'(rnd_c);
    assign e_c   = rnd_c ? ((~low_c) + EW'(1)) : low_c;

    // Shared multiplier for the cross-multiplied error compare
    logic [EW-1:0] mul_a;
    logic [DW-1:0] mul_b;
    logic [PW-1:0] prod;
    assign mul_a = (r_state == S_MULA) ? e_c  : r_be;
    assign mul_b = (r_state == S_MULA) ? r_bd : r_d;
    assign prod  = PW'(mul_a) * PW'(mul_b);

    // Candidate decision
    logic cand_c;
    logic win_c;
    logic stop_c;
    assign cand_c = (r_n != '0);
    assign win_c  = cand_c && (!r_found || (r_p < r_q));
    assign stop_c = (cand_c && (r_e == '0)) || (r_d == D_LIMIT);

    // Restoring divider step: one quotient bit a cycle
    logic [DW:0]   rem_sh;
    logic          ge_c;
    logic [DW-1:0] rem_next;
    logic [NW-1:0] quo_next;
    assign rem_sh   = {r_rem, r_dq[NW-1]};
    assign ge_c     = (rem_sh >= {1'b0, r_dvs});
    assign rem_next = ge_c ? DW'(rem_sh - {1'b0, r_dvs}) : rem_sh[DW-1:0];
    assign quo_next = {r_dq[NW-2:0], ge_c};

    // Final gcd once one operand has reached zero
    logic [DW-1:0] g_c;
    assign g_c = (r_gb == '0) ? DW'(r_ga << r_k) : DW'(r_gb << r_k);

    // Saturation and sign for the output
    logic [QW-1:0]    qn_ext;
    logic [DXW-1:0]   qd_ext;
    logic [NUM_W-2:0] num_mag;
    logic [NUM_W-1:0] num_c;
    logic [DEN_W-1:0] den_c;
    assign qn_ext  = QW'(r_qn);
    assign qd_ext  = DXW'(r_qd);
    assign num_mag = (qn_ext > QW'(NUM_MAG_MAX)) ? NUM_MAG_MAX : qn_ext[NUM_W-2:0];
    assign num_c   = r_neg ? (NUM_W'(0) - {1'b0, num_mag}) : {1'b0, num_mag};
    assign den_c   = (qd_ext > DXW'(DEN_MAX)) ? DEN_MAX : qd_ext[DEN_W-1:0];

    logic out_free;
    assign out_free = !r_out_valid || i_out_ready;

    // Sequencer and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // result held until taken, reloaded from the done state
            r_out_valid <= ((r_state == S_DONE) && out_free) ||
                           (r_out_valid && !i_out_ready);
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_mag    <= mag_c;
                        r_neg    <= i_value[VALUE_W-1];
                        r_scaled <= SW'(mag_c);
                        r_d      <= DW'(1);
                        r_found  <= 1'b0;
                        r_bd     <= DW'(1);
                        r_be     <= '0;
                        r_state  <= (mag_c == '0) ? S_DONE : S_MULA;
                    end
                end
                S_MULA: begin
                    r_n     <= n_c;
                    r_e     <= e_c;
                    r_p     <= prod;
                    r_state <= S_MULB;
                end
                S_MULB: begin
                    r_q     <= prod;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (win_c) begin
                        r_found <= 1'b1;
                        r_bn    <= r_n;
                        r_bd    <= r_d;
                        r_be    <= r_e;
                    end
                    if (stop_c) begin
                        if (win_c || r_found) begin
                            r_dq    <= win_c ? r_n : r_bn;
                            r_dvs   <= win_c ? r_d : r_bd;
                            r_rem   <= '0;
                            r_cnt   <= '0;
                            r_job   <= JOB_MOD;
                            r_state <= S_DIV;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end else begin
                        r_d      <= r_d + DW'(1);
                        r_scaled <= r_scaled + SW'(r_mag);
                        r_state  <= S_MULA;
                    end
                end
                S_DIV: begin
                    if (r_cnt != CNT_END) begin
                        r_dq  <= quo_next;
                        r_rem <= rem_next;
                        r_cnt <= r_cnt + CW'(1);
                    end else begin
                        unique case (r_job)
                            JOB_MOD: begin
                                r_ga    <= r_bd;
                                r_gb    <= rem_next;
                                r_k     <= '0;
                                r_state <= S_GCD;
                            end
                            JOB_NUM: begin
                                r_qn    <= quo_next;
                                r_dq    <= NW'(r_bd);
                                r_dvs   <= r_g;
                                r_rem   <= '0;
                                r_cnt   <= '0;
                                r_job   <= JOB_DEN;
                            end
                            JOB_DEN: begin
                                r_qd    <= quo_next[DW-1:0];
                                r_state <= S_DONE;
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_GCD: begin
                    // binary gcd on the denominator and the remainder
                    priority if ((r_gb == '0) || (r_ga == '0)) begin
                        r_g     <= g_c;
                        r_dq    <= r_bn;
                        r_dvs   <= g_c;
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_job   <= JOB_NUM;
                        r_state <= S_DIV;
                    end else if (!r_ga[0] && !r_gb[0]) begin
                        r_ga <= r_ga >> 1;
                        r_gb <= r_gb >> 1;
                        r_k  <= r_k + KW'(1);
                    end else if (!r_ga[0]) begin
                        r_ga <= r_ga >> 1;
                    end else if (!r_gb[0]) begin
                        r_gb <= r_gb >> 1;
                    end else if (r_ga >= r_gb) begin
                        r_ga <= r_ga - r_gb;
                    end else begin
                        r_gb <= r_gb - r_ga;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_fb        <= !r_found;
                        r_num       <= r_found ? num_c : '0;
                        r_den       <= r_found ? den_c : DEN_W'(1);
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready         = (r_state == S_IDLE);
    assign o_out_valid        = r_out_valid;
    assign o_numerator        = r_num;
    assign o_denominator      = r_den;
    assign o_decimal_fallback = r_fb;

    // Checks
    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request taken while previous one still in progress");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_dvs != '0))
        else $error("divider running with zero divisor");

    a_den_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_MULA) || (r_state == S_MULB) || (r_state == S_CMP))
            |-> ((r_d != '0) && (r_d <= D_LIMIT)))
        else $error("search denominator out of range");

    a_fallback_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_decimal_fallback)
            |-> ((o_numerator == '0) && (o_denominator == DEN_W'(1))))
        else $error("fallback result not zero over one");

    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_denominator != '0))
        else $error("zero denominator on output");

endmodule

[verif/bounded_rational_approximation_tb.sv]
// Self-checking testbench for the bounded rational approximation block.
module bounded_rational_approximation_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bra_pkg::*;

    localparam int DEN_LIMIT   = 128;
    localparam int FRAC_BITS   = 16;
    localparam int CYCLE_LIMIT = 4_000_000;

    // One expected fraction, tagged with the request value that produced it
    typedef struct {
        logic [VALUE_W-1:0]      value;
        logic signed [NUM_W-1:0] numerator;
        logic [DEN_W-1:0]        denominator;
        logic                    fallback;
    } t_fraction;

    logic                      i_clk;
    logic                      i_rst_n    = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_ready;
    logic signed [VALUE_W-1:0] i_value    = '0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic signed [NUM_W-1:0]   o_numerator;
    logic [DEN_W-1:0]          o_denominator;
    logic                      o_decimal_fallback;

    logic [VALUE_W-1:0] request_values[$];
    t_fraction          expected_fractions[$];
    t_fraction          oldest_fraction;
    int                 send_idle_pct  = 0;
    int                 recv_stall_pct = 0;
    int                 mismatch_count = 0;
    int                 cycle_count    = 0;

    bounded_rational_approximation #(
        .DENOMINATOR_LIMIT (DEN_LIMIT),
        .FRACTION_BITS     (FRAC_BITS)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_value            (i_value),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_numerator        (o_numerator),
        .o_denominator      (o_denominator),
        .o_decimal_fallback (o_decimal_fallback)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Closest fraction with denominator up to DEN_LIMIT, reduced and signed
    function automatic t_fraction closest_fraction(logic [VALUE_W-1:0] value);
        logic [VALUE_W:0] mag;
        logic [63:0]      scaled, cand, approx, err;
        logic [63:0]      top_num, top_den, top_err;
        logic [63:0]      gcd_a, gcd_b, rem, red_num, red_den;
        logic [NUM_W-1:0] num_mag;
        logic             found, hit;
        int               den;
        t_fraction        res;
        mag      = value[VALUE_W-1] ? ({1'b1, {VALUE_W{1'b0}}} - {1'b0, value})
                                    : {1'b0, value};
        found    = 1'b0;
        hit      = 1'b0;
        top_num  = '0;
        top_den  = 64'd1;
        top_err  = '0;
        res.value = value;
        // Search every denominator; a zero magnitude finds nothing
        for (den = 1; den <= DEN_LIMIT && !hit && mag != 0; den++) begin
            scaled = 64'(mag) * 64'(den);
            cand   = (scaled + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
            if (cand != 0) begin
                approx = cand << FRAC_BITS;
                err    = (scaled >= approx) ? scaled - approx : approx - scaled;
                // strictly smaller error only, so ties keep the earlier denominator
                if (!found || err * top_den < top_err * 64'(den)) begin
                    found   = 1'b1;
                    top_num = cand;
                    top_den = 64'(den);
                    top_err = err;
                end
                hit = (err == 0);
            end
        end
        if (!found) begin
            res.numerator   = '0;
            res.denominator = DEN_W'(1);
            res.fallback    = 1'b1;
            return res;
        end
        // Reduce by the greatest common divisor
        gcd_a = top_num;
        gcd_b = top_den;
        while (gcd_b != 0) begin
            rem   = gcd_a % gcd_b;
            gcd_a = gcd_b;
            gcd_b = rem;
        end
        red_num = top_num / gcd_a;
        red_den = top_den / gcd_a;
        if (red_num > 64'(NUM_MAG_MAX)) red_num = 64'(NUM_MAG_MAX);
        if (red_den > 64'(DEN_MAX)) red_den = 64'(DEN_MAX);
        num_mag         = red_num[NUM_W-1:0];
        res.numerator   = value[VALUE_W-1] ? -num_mag : num_mag;
        res.denominator = red_den[DEN_W-1:0];
        res.fallback    = 1'b0;
        return res;
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        $display("mismatch: %s", msg);
    endtask

    // Request driver: hold until accepted, then load the next or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_value    <= '0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                expected_fractions.push_back(closest_fraction(i_value));
            end
            if (!i_in_valid || o_in_ready) begin
                if (request_values.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_value    <= request_values.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare against the oldest expectation, random stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_fractions.size() == 0) begin
                    flag_mismatch($sformatf("result %0d/%0d fb=%0b with no request pending",
                                            o_numerator, o_denominator, o_decimal_fallback));
                end else begin
                    oldest_fraction = expected_fractions.pop_front();
                    if (o_numerator !== oldest_fraction.numerator)
                        flag_mismatch($sformatf("value %h: numerator %0d, want %0d",
                                                oldest_fraction.value, o_numerator,
                                                oldest_fraction.numerator));
                    if (o_denominator !== oldest_fraction.denominator)
                        flag_mismatch($sformatf("value %h: denominator %0d, want %0d",
                                                oldest_fraction.value, o_denominator,
                                                oldest_fraction.denominator));
                    if (o_decimal_fallback !== oldest_fraction.fallback)
                        flag_mismatch($sformatf("value %h: fallback %0b, want %0b",
                                                oldest_fraction.value, o_decimal_fallback,
                                                oldest_fraction.fallback));
                end
            end
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic wait_all_done();
        while (request_values.size() != 0 || i_in_valid || expected_fractions.size() != 0)
            @(posedge i_clk);
    endtask

    // One idling phase of random requests
    task automatic run_phase(input int send_pct, input int stall_pct, input int count);
        logic [63:0]        near;
        logic [VALUE_W-1:0] v;
        int                 den;
        int                 num;
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(5))
                0: v = $urandom;
                // around the fallback threshold
                1: v = $urandom_range(0, 600);
                // close to a fraction with an in-range denominator
                2: begin
                    den  = $urandom_range(1, DEN_LIMIT);
                    num  = $urandom_range(1, 30000);
                    near = (64'(num) << FRAC_BITS) / 64'(den);
                    v    = near[VALUE_W-1:0] + $urandom_range(0, 8) - 4;
                end
                3: v = $urandom & 32'h000F_FFFF;
                // next to the extremes
                4: v = ($urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000)
                       ^ $urandom_range(0, 255);
                default: v = $urandom & 32'h0000_FFFF;
            endcase
            if ($urandom_range(1) && v != 32'h8000_0000) v = -v;
            request_values.push_back(v);
        end
        wait_all_done();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: zero, too small, threshold, exact hits, extremes
        request_values = '{
            32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_00FF,
            32'hFFFF_FF01, 32'h0000_0100, 32'hFFFF_FF00, 32'h0000_0101,
            32'h0000_0200, 32'h0000_8000, 32'h0001_0000, 32'hFFFF_0000,
            32'h0001_8000, 32'h0000_FFFF, 32'h0000_5555, 32'h0000_AAAB,
            32'h0003_243F, 32'hFFFC_DBC1, 32'h7FFF_FFFF, 32'h8000_0000,
            32'h8000_0001, 32'h7FFF_0000, 32'h5555_5555, 32'hAAAA_AAAA
        };
        wait_all_done();

        run_phase(0, 0, 270);
        run_phase(64, 0, 270);
        run_phase(0, 64, 270);
        run_phase(33, 33, 270);

        repeat (600) @(posedge i_clk);
        if (mismatch_count == 0 && expected_fractions.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
